@@ sv/life_rle_run_decoder_defines.svh @@
// Assertion macros shared by the run decoder checkers.
// No dependencies; each file that asserts includes this header.
`ifndef LIFE_RLE_RUN_DECODER_DEFINES_SVH
`define LIFE_RLE_RUN_DECODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define LRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("run decoder check failed");

// Next-cycle implication, ignored while reset is high
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("run decoder check failed");

// Same-cycle implication that also holds across reset
`define LRD_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("run decoder check failed");

`endif

@@ sv/lrd_pkg.sv @@
// Shared types and constants for the run-length pattern decoder.
// No dependencies; used by lrd_step and life_rle_run_decoder.
package lrd_pkg;

  // Fixed field widths
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int START_W   = 24;
  localparam int LEN_W     = 16;

  // Limits that follow from the field widths
  localparam int CFG_LIMIT = 2**CFG_W - 1;
  localparam int LEN_LIMIT = 2**LEN_W - 1;

  // Defaults for top-level parameters and register reset
  localparam int MAX_SIDE_DEF = 4096;
  localparam int RUN_MAX_DEF  = 65535;
  localparam int SIDE_RESET   = 64;

  // Characters of the data section
  localparam logic [CHAR_W-1:0] CH_DEAD = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LIVE = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_ROW  = 8'h24;
  localparam logic [CHAR_W-1:0] CH_END  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_RUN,
    OP_ROW,
    OP_END
  } op_t;

  // One decoded result, plus whether the item produces one at all
  typedef struct packed {
    logic               emit;
    logic [START_W-1:0] start_index;
    logic [LEN_W-1:0]   run_length;
    logic               cell_alive;
    logic               clipped;
    logic               pattern_end;
  } result_t;

endpackage

@@ sv/lrd_step.sv @@
// Decode state and update for one character of run-length data.
// Depends on lrd_pkg; instantiated by life_rle_run_decoder.
module lrd_step #(
  parameter int SIDE_MAX  = lrd_pkg::MAX_SIDE_DEF,
  parameter int COUNT_CAP = lrd_pkg::RUN_MAX_DEF,
  localparam int SIDE_W   = $clog2(SIDE_MAX + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [lrd_pkg::CHAR_W-1:0] ch,
  input  logic [SIDE_W-1:0]          cols,
  input  logic [SIDE_W-1:0]          rows,
  output lrd_pkg::result_t           res
);

  localparam int LEN_W   = lrd_pkg::LEN_W;
  localparam int START_W = lrd_pkg::START_W;
  localparam int CELL_W  = 2 * SIDE_W;
  localparam int PROD_W  = LEN_W + SIDE_W;
  localparam int SUM_W   = ((CELL_W > PROD_W) ? CELL_W : PROD_W) + 1;
  localparam int CMP_W   = (CELL_W > LEN_W) ? CELL_W : LEN_W;
  localparam int EXT_W   = (CELL_W > START_W) ? CELL_W : START_W;
  localparam int DIG_W   = LEN_W + 4;

  // Decode state
  logic [LEN_W-1:0]  run_count, run_count_next;
  logic              count_seen, count_seen_next;
  logic [CELL_W-1:0] row_base, row_base_next;
  logic [CELL_W-1:0] cursor, cursor_next;
  logic              finished, finished_next;

  lrd_pkg::op_t      op;
  logic [CELL_W-1:0] cells;
  logic [LEN_W-1:0]  want;
  logic [CELL_W-1:0] left;
  logic [CMP_W-1:0]  left_x;
  logic              short_run;
  logic [LEN_W-1:0]  len;
  logic [CMP_W-1:0]  cursor_sum;
  logic [PROD_W-1:0] row_step;
  logic [SUM_W-1:0]  row_sum;
  logic [CELL_W-1:0] row_new;
  logic [DIG_W-1:0]  dig_sum;
  logic [LEN_W-1:0]  count_dig;
  logic [EXT_W-1:0]  cursor_ext;

  // Classify the character; nothing counts once the end is seen
  always_comb begin
    op = lrd_pkg::OP_NONE;
    if (!finished) begin
      unique case (ch) inside
        [lrd_pkg::CH_ZERO:lrd_pkg::CH_NINE]: op = lrd_pkg::OP_DIGIT;
        lrd_pkg::CH_DEAD, lrd_pkg::CH_LIVE:  op = lrd_pkg::OP_RUN;
        lrd_pkg::CH_ROW:                     op = lrd_pkg::OP_ROW;
        lrd_pkg::CH_END:                     op = lrd_pkg::OP_END;
        default:                             op = lrd_pkg::OP_NONE;
      endcase
    end
  end

  // Grid size and the pending count (one when no digit came)
  assign cells = CELL_W'(cols) * CELL_W'(rows);
  assign want  = count_seen ? run_count : LEN_W'(1);

  // Clip the run at the grid end
  assign left       = (cursor < cells) ? (cells - cursor) : '0;
  assign left_x     = CMP_W'(left);
  assign short_run  = left_x < CMP_W'(want);
  assign len        = short_run ? left_x[LEN_W-1:0] : want;
  assign cursor_sum = CMP_W'(cursor) + CMP_W'(len);

  // Advance the row base by count rows, saturating at the cell count
  assign row_step = PROD_W'(want) * PROD_W'(cols);
  assign row_sum  = SUM_W'(row_base) + SUM_W'(row_step);
  assign row_new  = (row_sum > SUM_W'(cells)) ? cells : row_sum[CELL_W-1:0];

  // Accumulate a decimal digit, saturating at the cap
  assign dig_sum   = DIG_W'({run_count, 3'b000}) + DIG_W'({run_count, 1'b0})
                   + DIG_W'(ch - lrd_pkg::CH_ZERO);
  assign count_dig = (dig_sum > DIG_W'(COUNT_CAP)) ? LEN_W'(COUNT_CAP)
                                                   : dig_sum[LEN_W-1:0];

  assign cursor_ext = EXT_W'(cursor);

  // Next state and result
  always_comb begin
    run_count_next  = run_count;
    count_seen_next = count_seen;
    row_base_next   = row_base;
    cursor_next     = cursor;
    finished_next   = finished;
    res.emit        = 1'b0;
    res.start_index = cursor_ext[START_W-1:0];
    res.run_length  = '0;
    res.cell_alive  = 1'b0;
    res.clipped     = 1'b0;
    res.pattern_end = 1'b0;
    unique case (op)
      lrd_pkg::OP_DIGIT: begin
        run_count_next  = count_dig;
        count_seen_next = 1'b1;
      end
      lrd_pkg::OP_RUN: begin
        run_count_next  = '0;
        count_seen_next = 1'b0;
        cursor_next     = cursor_sum[CELL_W-1:0];
        res.emit        = 1'b1;
        res.run_length  = len;
        res.cell_alive  = (ch == lrd_pkg::CH_LIVE);
        res.clipped     = short_run;
      end
      lrd_pkg::OP_ROW: begin
        run_count_next  = '0;
        count_seen_next = 1'b0;
        row_base_next   = row_new;
        cursor_next     = row_new;
      end
      lrd_pkg::OP_END: begin
        run_count_next  = '0;
        count_seen_next = 1'b0;
        finished_next   = 1'b1;
        res.emit        = 1'b1;
        res.pattern_end = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Commit the update when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= '0;
      count_seen <= 1'b0;
      row_base   <= '0;
      cursor     <= '0;
      finished   <= 1'b0;
    end else if (go) begin
      run_count  <= run_count_next;
      count_seen <= count_seen_next;
      row_base   <= row_base_next;
      cursor     <= cursor_next;
      finished   <= finished_next;
    end
  end

endmodule

@@ sv/life_rle_run_decoder.sv @@
// Run decoder for the data section of a run-length encoded cellular pattern.
// It takes one character per cycle, back to back, while in_stall is low, and
// presents one result for each 'b', 'o' or '!' character up to the end marker,
// through the input register and then the output register: a row-major start
// index, a clipped run length, the cell value and flags.
// The rate is one item per cycle when nothing stalls, set by the decode state
// (count, cursor, row base) that each character updates. A held result
// in the output register does not block input until the input register
// also holds an item that produces a result. Grid size is written through
// the configuration port; out-of-range sides are clamped to 1..MAX_SIDE.
// Depends on lrd_pkg and lrd_step.
module life_rle_run_decoder #(
  parameter int MAX_SIDE = lrd_pkg::MAX_SIDE_DEF,
  parameter int RUN_MAX  = lrd_pkg::RUN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input characters
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrd_pkg::CHAR_W-1:0]    char_in,
  // decoded runs
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrd_pkg::START_W-1:0]   start_index,
  output logic [lrd_pkg::LEN_W-1:0]     run_length,
  output logic                          cell_alive,
  output logic                          clipped,
  output logic                          pattern_end,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SIDE_MAX  = (MAX_SIDE < lrd_pkg::CFG_LIMIT) ? MAX_SIDE
                                                             : lrd_pkg::CFG_LIMIT;
  localparam int COUNT_CAP = (RUN_MAX < lrd_pkg::LEN_LIMIT) ? RUN_MAX
                                                            : lrd_pkg::LEN_LIMIT;
  localparam int SIDE_W    = $clog2(SIDE_MAX + 1);
  localparam int SIDE_RST  = (lrd_pkg::SIDE_RESET > SIDE_MAX) ? SIDE_MAX
                                                              : lrd_pkg::SIDE_RESET;

  logic [SIDE_W-1:0]          cols, rows;
  logic [SIDE_W-1:0]          side_wr;
  logic                       s1_valid;
  logic [lrd_pkg::CHAR_W-1:0] s1_char;
  logic                       s1_go;
  logic                       out_free;
  lrd_pkg::result_t           res;

  // Clamp the written side to 1..SIDE_MAX
  always_comb begin
    if (cfg_data == '0) begin
      side_wr = SIDE_W'(1);
    end else if (cfg_data > lrd_pkg::CFG_W'(SIDE_MAX)) begin
      side_wr = SIDE_W'(SIDE_MAX);
    end else begin
      side_wr = SIDE_W'(cfg_data);
    end
  end

  assign cfg_ready = 1'b1;

  // Grid size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= SIDE_W'(SIDE_RST);
      rows <= SIDE_W'(SIDE_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (lrd_pkg::cfg_reg_t'(cfg_index))
        lrd_pkg::CFG_COLS: cols <= side_wr;
        lrd_pkg::CFG_ROWS: rows <= side_wr;
        default: begin
        end
      endcase
    end
  end

  // Input register advances unless its result has nowhere to go
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!res.emit || out_free);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= char_in;
    end
  end

  lrd_step #(
    .SIDE_MAX  (SIDE_MAX),
    .COUNT_CAP (COUNT_CAP)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (s1_go),
    .ch   (s1_char),
    .cols (cols),
    .rows (rows),
    .res  (res)
  );

  // Result register: load a new item, drop a delivered one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      start_index <= res.start_index;
      run_length  <= res.run_length;
      cell_alive  <= res.cell_alive;
      clipped     <= res.clipped;
      pattern_end <= res.pattern_end;
    end
  end

endmodule

@@ sv/lrd_checker.sv @@
// Port-level checks for life_rle_run_decoder, attached by bind.
// Depends on life_rle_run_decoder_defines.svh and lrd_pkg.
`include "life_rle_run_decoder_defines.svh"

module lrd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lrd_pkg::START_W-1:0]   start_index,
  input logic [lrd_pkg::LEN_W-1:0]     run_length,
  input logic                          cell_alive,
  input logic                          clipped,
  input logic                          pattern_end
);

  localparam int WORD_W = lrd_pkg::START_W + lrd_pkg::LEN_W + 3;

  logic              ended;
  logic [WORD_W-1:0] out_word;

  assign out_word = {start_index, run_length, cell_alive, clipped, pattern_end};

  // Track delivery of the end marker
  always_ff @(posedge clk) begin
    if (rst) begin
      ended <= 1'b0;
    end else if (out_valid && !out_stall && pattern_end) begin
      ended <= 1'b1;
    end
  end

  // A stalled result holds
  `LRD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // The end marker carries no run
  `LRD_ASSERT_NOW(a_end_empty, clk, rst, out_valid && pattern_end, ~|run_length && !cell_alive && !clipped)

  // Nothing follows a delivered end marker
  `LRD_ASSERT_NOW(a_quiet_after_end, clk, rst, ended, !out_valid)

  // Leaving reset, no result is pending and input is open
  `LRD_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) && !rst, !out_valid && !in_stall)

endmodule

bind life_rle_run_decoder lrd_checker u_lrd_checker (.*);
